// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wps_pkg.sv =====
`timescale 1ns / 1ps

package wps_pkg;

  localparam int OUT_W         = 20;
  localparam int OUT_FRAC_BITS = 12;
  localparam int QF            = 24;
  localparam int LF            = 30;
  localparam int QW            = 56;

  localparam int DIV_STAGES  = QW;
  localparam int LOG_STAGES  = LF;
  localparam int EXP_STAGES  = LF;
  localparam int DIV3_BITS   = 6;
  localparam int DIV3_STAGES = 6;
  localparam int B3W         = DIV3_BITS * DIV3_STAGES;
  localparam int ENC_STAGES  = 1 + LOG_STAGES + 1 + DIV3_STAGES + 1 + EXP_STAGES + 3;
  localparam int LANE_LAT    = DIV_STAGES + ENC_STAGES;

  localparam int LIN_SHIFT = QF + 16 - OUT_FRAC_BITS;
  localparam int CRV_SHIFT = 50 - OUT_FRAC_BITS;

  localparam logic [QW-1:0] LIN_THRESH = QW'(52525);
  localparam logic [19:0]   LIN_GAIN   = 20'd846725;
  localparam logic [20:0]   ENC_GAIN   = 21'd1106248;
  localparam logic [63:0]   CRV_OFFSET = (64'd11 << 50) / 64'd200;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] red_sum;
    logic signed [31:0] green_sum;
    logic signed [31:0] blue_sum;
    logic signed [31:0] weight_sum;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] red_srgb;
    logic signed [OUT_W-1:0] green_srgb;
    logic signed [OUT_W-1:0] blue_srgb;
  } srgb_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xv;
    xv = x;
    r  = '0;
    b  = 64'd1 << 62;
    while (b > xv) b = b >> 2;
    while (b != 64'd0) begin
      if (xv >= r + b) begin
        xv = xv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) with LF fraction bits, by repeated truncated square roots
  function automatic logic [63:0] exp_root(input int k);
    logic [63:0] r;
    r = 64'd2 << LF;
    for (int i = 1; i <= k; i++) r = isqrt64(r << LF);
    return r;
  endfunction

endpackage

// ===== rtl/wps_div.sv =====
`timescale 1ns / 1ps

module wps_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [31:0]      num,
  input  logic signed [31:0]      den,
  output logic [wps_pkg::QW-1:0]  quo,
  output logic                    neg,
  output logic [5:0]              msb
);
  import wps_pkg::*;

  logic [31:0]   rem_r   [QW];
  logic [31:0]   nm_r    [QW];
  logic [31:0]   dm_r    [QW];
  logic [QW-1:0] quo_r   [QW];
  logic          found_r [QW];
  logic [5:0]    msb_r   [QW];
  logic          neg_r   [QW];

  logic [31:0] nm_in;
  logic [31:0] dm_in;

  assign nm_in = num[31] ? 32'(-num) : 32'(num);
  assign dm_in = den[31] ? 32'(-den) : 32'(den);

  // one quotient bit per stage, msb first; the first set bit gives the exponent
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [31:0]   rem_i;
    logic [31:0]   nm_i;
    logic [31:0]   dm_i;
    logic [QW-1:0] quo_i;
    logic          found_i;
    logic [5:0]    msb_i;
    logic          neg_i;
    logic          nbit;
    logic [32:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_i   = '0;
      assign nm_i    = nm_in;
      assign dm_i    = dm_in;
      assign quo_i   = '0;
      assign found_i = 1'b0;
      assign msb_i   = '0;
      assign neg_i   = num[31] ^ den[31];
    end else begin : g_next
      assign rem_i   = rem_r[s-1];
      assign nm_i    = nm_r[s-1];
      assign dm_i    = dm_r[s-1];
      assign quo_i   = quo_r[s-1];
      assign found_i = found_r[s-1];
      assign msb_i   = msb_r[s-1];
      assign neg_i   = neg_r[s-1];
    end

    if (B >= QF) begin : g_bit
      assign nbit = nm_i[B-QF];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {rem_i, nbit};
    assign ge    = trial >= {1'b0, dm_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]   <= ge ? 32'(trial - {1'b0, dm_i}) : trial[31:0];
        nm_r[s]    <= nm_i;
        dm_r[s]    <= dm_i;
        quo_r[s]   <= {quo_i[QW-2:0], ge};
        found_r[s] <= found_i | ge;
        msb_r[s]   <= (ge && !found_i) ? 6'(B) : msb_i;
        neg_r[s]   <= neg_i;
      end
    end
  end

  assign quo = quo_r[QW-1];
  assign neg = neg_r[QW-1];
  assign msb = msb_r[QW-1];

endmodule

// ===== rtl/wps_enc.sv =====
`timescale 1ns / 1ps

module wps_enc (
  input  logic                             clk,
  input  logic                             en,
  input  logic [wps_pkg::QW-1:0]           quo,
  input  logic                             neg,
  input  logic [5:0]                       msb,
  output logic signed [wps_pkg::OUT_W-1:0] res
);
  import wps_pkg::*;

  typedef struct packed {
    logic             lin;
    logic [OUT_W-1:0] lin_val;
    logic [5:0]       n;
    logic signed [4:0] ip;
    logic             big;
  } ctl_t;

  // normalize and linear product
  logic [40:0] mag41;
  logic [30:0] m_in;
  logic [60:0] lprod;
  logic        neg0;
  logic [30:0] m0;
  ctl_t        ctl0;

  always_comb begin
    mag41 = (quo > (QW'(1) << 40)) ? {1'b1, 40'd0} : quo[40:0];
    if (msb >= 6'd30) m_in = 31'(quo >> (msb - 6'd30));
    else              m_in = 31'(quo << (6'd30 - msb));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lprod        <= 61'(mag41) * 61'(LIN_GAIN);
      neg0         <= neg;
      m0           <= m_in;
      ctl0.lin     <= neg || (quo <= LIN_THRESH);
      ctl0.lin_val <= '0;
      ctl0.n       <= msb;
      ctl0.ip      <= '0;
      ctl0.big     <= 1'b0;
    end
  end

  // log2 of the mantissa, one squaring per stage
  logic [30:0]   lm   [LOG_STAGES];
  logic [LF-1:0] lfr  [LOG_STAGES];
  ctl_t          lctl [LOG_STAGES];

  for (genvar k = 0; k < LOG_STAGES; k++) begin : g_log
    logic [30:0]   m_i;
    logic [LF-1:0] fr_i;
    ctl_t          ctl_i;
    logic [61:0]   sq;
    logic [31:0]   s2;

    if (k == 0) begin : g_first
      logic [60:0] lr;
      always_comb begin
        lr    = (lprod + (61'(1) << (LIN_SHIFT - 1))) >> LIN_SHIFT;
        ctl_i = ctl0;
        if (neg0) ctl_i.lin_val = (lr > (61'(1) << (OUT_W - 1))) ? OUT_MIN : OUT_W'(-lr);
        else      ctl_i.lin_val = (lr > 61'(OUT_MAX)) ? OUT_MAX : lr[OUT_W-1:0];
      end
      assign m_i  = m0;
      assign fr_i = '0;
    end else begin : g_next
      assign m_i   = lm[k-1];
      assign fr_i  = lfr[k-1];
      assign ctl_i = lctl[k-1];
    end

    assign sq = 62'(m_i) * 62'(m_i);
    assign s2 = sq[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        lm[k]   <= s2[31] ? s2[31:1] : s2[30:0];
        lfr[k]  <= {fr_i[LF-2:0], s2[31]};
        lctl[k] <= ctl_i;
      end
    end
  end

  // scale by 5/12: times five, quarter, then thirds
  logic signed [36:0] lg;
  logic [35:0]        lmag;
  logic [37:0]        a5;
  logic [B3W-1:0]     b0;
  logic               yneg0;
  ctl_t               ctl_s;

  always_comb begin
    lg   = {7'({1'b0, lctl[LOG_STAGES-1].n} - 7'd24), lfr[LOG_STAGES-1]};
    lmag = lg[36] ? 36'(-lg) : lg[35:0];
    a5   = (38'(lmag) << 2) + 38'(lmag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0    <= B3W'(a5 >> 2);
      yneg0 <= lg[36];
      ctl_s <= lctl[LOG_STAGES-1];
    end
  end

  logic [B3W-1:0] db   [DIV3_STAGES];
  logic [B3W-1:0] dq   [DIV3_STAGES];
  logic [1:0]     dr   [DIV3_STAGES];
  logic           dneg [DIV3_STAGES];
  ctl_t           dctl [DIV3_STAGES];

  for (genvar t = 0; t < DIV3_STAGES; t++) begin : g_div3
    localparam int TOP = B3W - 1 - DIV3_BITS * t;
    logic [B3W-1:0]       b_i;
    logic [B3W-1:0]       q_i;
    logic [1:0]           r_i;
    logic                 neg_i;
    ctl_t                 ctl_i;
    logic [1:0]           r_o;
    logic [DIV3_BITS-1:0] qb;
    logic [2:0]           x;

    if (t == 0) begin : g_first
      assign b_i   = b0;
      assign q_i   = '0;
      assign r_i   = '0;
      assign neg_i = yneg0;
      assign ctl_i = ctl_s;
    end else begin : g_next
      assign b_i   = db[t-1];
      assign q_i   = dq[t-1];
      assign r_i   = dr[t-1];
      assign neg_i = dneg[t-1];
      assign ctl_i = dctl[t-1];
    end

    always_comb begin
      r_o = r_i;
      qb  = '0;
      x   = '0;
      for (int j = 0; j < DIV3_BITS; j++) begin
        x = {r_o, b_i[TOP-j]};
        if (x >= 3'd3) begin
          r_o                   = 2'(x - 3'd3);
          qb[DIV3_BITS-1-j]     = 1'b1;
        end else begin
          r_o = x[1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        db[t]   <= b_i;
        dq[t]   <= {q_i[B3W-DIV3_BITS-1:0], qb};
        dr[t]   <= r_o;
        dneg[t] <= neg_i;
        dctl[t] <= ctl_i;
      end
    end
  end

  // split into integer exponent and fraction
  logic signed [B3W:0] y;
  logic [6:0]          ip7;
  logic [LF-1:0]       f0;
  ctl_t                ctl_y_next;
  ctl_t                ctl_y;

  always_comb begin
    y   = dneg[DIV3_STAGES-1] ? -$signed({1'b0, dq[DIV3_STAGES-1]})
                              : $signed({1'b0, dq[DIV3_STAGES-1]});
    ip7 = 7'(y >>> LF);
    ctl_y_next     = dctl[DIV3_STAGES-1];
    ctl_y_next.ip  = ip7[4:0];
    ctl_y_next.big = $signed(ip7) >= 7'sd12;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0    <= y[LF-1:0];
      ctl_y <= ctl_y_next;
    end
  end

  // exp2 of the fraction, one root factor per stage
  logic [30:0]   ep   [EXP_STAGES];
  logic [LF-1:0] ef   [EXP_STAGES];
  ctl_t          ectl [EXP_STAGES];

  for (genvar e = 0; e < EXP_STAGES; e++) begin : g_exp
    localparam logic [30:0] ROOT = 31'(exp_root(e + 1));
    logic [30:0]   p_i;
    logic [LF-1:0] f_i;
    ctl_t          ctl_i;
    logic [61:0]   prod;

    if (e == 0) begin : g_first
      assign p_i   = 31'(1) << LF;
      assign f_i   = f0;
      assign ctl_i = ctl_y;
    end else begin : g_next
      assign p_i   = ep[e-1];
      assign f_i   = ef[e-1];
      assign ctl_i = ectl[e-1];
    end

    assign prod = 62'(p_i) * 62'(ROOT);

    always_ff @(posedge clk) begin
      if (en) begin
        ep[e]   <= f_i[LF-1-e] ? prod[60:30] : p_i;
        ef[e]   <= f_i;
        ectl[e] <= ctl_i;
      end
    end
  end

  // gain, exponent shift, offset and rounding, then the choice of linear, saturated or curve result
  logic [51:0] n50;
  ctl_t        ctl_g;
  logic [63:0] v;
  ctl_t        ctl_v;
  logic [63:0] d;
  logic [63:0] rr;
  logic [OUT_W-1:0] crv;

  always_ff @(posedge clk) begin
    if (en) begin
      n50   <= 52'(ep[EXP_STAGES-1]) * 52'(ENC_GAIN);
      ctl_g <= ectl[EXP_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!ctl_g.ip[4]) v <= 64'(n50) << ctl_g.ip[3:0];
      else              v <= 64'(n50) >> 4'(-ctl_g.ip);
      ctl_v <= ctl_g;
    end
  end

  always_comb begin
    d   = v - CRV_OFFSET;
    rr  = (d + (64'(1) << (CRV_SHIFT - 1))) >> CRV_SHIFT;
    if (v <= CRV_OFFSET)         crv = '0;
    else if (rr > 64'(OUT_MAX))  crv = OUT_MAX;
    else                         crv = rr[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_v.lin)      res <= ctl_v.lin_val;
      else if (ctl_v.big) res <= OUT_MAX;
      else                res <= crv;
    end
  end

endmodule

// ===== rtl/weighted_pixel_to_srgb.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Weighted pixel to sRGB encoder. Each pixel's red, green and blue sums are
// divided by the weight sum and sent through the sRGB transfer curve in three
// identical lanes; a zero weight gives black. A pixel goes through the
// 56-stage bit-per-stage divider, the 72-stage log/exp curve pipeline and
// the output register. One pixel is accepted every cycle, but when the
// output item is not taken the whole pipeline holds and pixel_ready drops.
module weighted_pixel_to_srgb (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  output logic            pixel_ready,
  input  wps_pkg::pixel_t pixel,
  output logic            srgb_valid,
  input  logic            srgb_ready,
  output wps_pkg::srgb_t  srgb
);
  import wps_pkg::*;

  logic                    adv;
  logic [LANE_LAT-1:0]     vld;
  logic [LANE_LAT-1:0]     zero;
  logic signed [31:0]      sums [3];
  logic [QW-1:0]           quo  [3];
  logic                    neg  [3];
  logic [5:0]              msb  [3];
  logic signed [OUT_W-1:0] res  [3];

  assign adv         = !srgb_valid || srgb_ready;
  assign pixel_ready = adv;

  assign sums[0] = pixel.red_sum;
  assign sums[1] = pixel.green_sum;
  assign sums[2] = pixel.blue_sum;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    wps_div u_div (
      .clk (clk),
      .en  (adv),
      .num (sums[c]),
      .den (pixel.weight_sum),
      .quo (quo[c]),
      .neg (neg[c]),
      .msb (msb[c])
    );

    wps_enc u_enc (
      .clk (clk),
      .en  (adv),
      .quo (quo[c]),
      .neg (neg[c]),
      .msb (msb[c]),
      .res (res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LANE_LAT-2:0], pixel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero <= {zero[LANE_LAT-2:0], pixel.weight_sum == 32'sd0};
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      srgb_valid <= 1'b0;
    end else if (adv) begin
      srgb_valid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero[LANE_LAT-1]) srgb <= '0;
      else                  srgb <= {res[0], res[1], res[2]};
    end
  end

  `ASSERT_NEXT(a_zero_weight_black, vld[LANE_LAT-1] && zero[LANE_LAT-1] && adv, srgb == '0, "empty pixel did not give black")
  `ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(vld), "valid pipeline moved while stalled")
  `ASSERT_CLK(a_ready_when_empty, !srgb_valid |-> pixel_ready, "not ready with empty output register")

endmodule

// ===== tb/tb_weighted_pixel_to_srgb.sv =====
`timescale 1ns / 1ps

module tb_weighted_pixel_to_srgb;
  import wps_pkg::*;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_ready;
  pixel_t pixel = '0;
  logic   srgb_valid;
  logic   srgb_ready = 1'b0;
  srgb_t  srgb;

  pixel_t pending_pixels[$];
  srgb_t  expected_srgb[$];
  int     mismatches = 0;
  int     send_idle_pct = 27;
  int     recv_idle_pct = 64;

  weighted_pixel_to_srgb i_dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel),
    .srgb_valid (srgb_valid),
    .srgb_ready (srgb_ready),
    .srgb       (srgb)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // signed quotient with 24 fraction bits, magnitude truncated
  function automatic longint div_q24(longint num, longint den);
    logic [63:0] nm;
    logic [63:0] dm;
    logic [63:0] qm;
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    qm = (nm << 24) / dm;
    return ((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm);
  endfunction

  function automatic logic [OUT_W-1:0] encode_channel(longint q);
    logic [63:0] u, m, fr, p, r, n50, v, d, res, mag, f, c;
    int n, ip;
    longint lg, y, yo;
    if (q <= 52525) begin
      mag = q < 0 ? -q : q;
      if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      r = (mag * 64'd846725 + (64'd1 << 27)) >> 28;
      if (q < 0) return (r > 64'd524288) ? OUT_MIN : OUT_W'(-r);
      return (r > 64'd524287) ? OUT_MAX : OUT_W'(r);
    end
    u = q;
    n = 63;
    while (!u[n]) n--;
    m = n >= 30 ? u >> (n - 30) : u << (30 - n);
    fr = '0;
    for (int k = 0; k < 30; k++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr = fr | 64'd1;
      end
    end
    lg = longint'(n - 24) * (longint'(1) << 30) + longint'(fr);
    y = lg * 5 / 12;
    yo = y + (longint'(16) << 30);
    ip = int'(yo >>> 30) - 16;
    f = yo & ((64'd1 << 30) - 64'd1);
    if (ip >= 12) return OUT_MAX;
    r = 64'd2 << 30;
    p = 64'd1 << 30;
    for (int k = 1; k <= 30; k++) begin
      r = floor_sqrt(r << 30);
      if (f[30-k]) p = (p * r) >> 30;
    end
    n50 = p * 64'd1106248;
    v = ip >= 0 ? n50 << ip : n50 >> (-ip);
    c = (64'd11 << 50) / 64'd200;
    if (v <= c) return '0;
    d = v - c;
    res = (d + (64'd1 << 37)) >> 38;
    if (res > 64'd524287) return OUT_MAX;
    return OUT_W'(res);
  endfunction

  function automatic srgb_t predict_srgb(pixel_t px);
    srgb_t o;
    longint w;
    w = px.weight_sum;
    o = '0;
    if (w != 0) begin
      o.red_srgb   = encode_channel(div_q24(px.red_sum, w));
      o.green_srgb = encode_channel(div_q24(px.green_sum, w));
      o.blue_srgb  = encode_channel(div_q24(px.blue_sum, w));
    end
    return o;
  endfunction

  // mostly quotients around the curve range, some full-range noise
  function automatic logic [31:0] pick_sum(longint w);
    int sel;
    longint s;
    sel = $urandom_range(0, 9);
    if (sel < 2) return $urandom;
    if (sel < 4) s = (w * longint'($urandom_range(0, 40))) / 10000;
    else if (sel < 5) s = -(w * longint'($urandom_range(0, 2000))) / 1000;
    else s = (w * longint'($urandom_range(0, 3000))) / 1000;
    return 32'(s);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    longint w;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) w = 0;
    else if (sel < 4) w = longint'($signed($urandom));
    else w = longint'($urandom_range(1, 32'h00ffffff));
    if (sel > 16) w = -w;
    px.weight_sum = 32'(w);
    px.red_sum    = pick_sum(w);
    px.green_sum  = pick_sum(w);
    px.blue_sum   = pick_sum(w);
    return px;
  endfunction

  function automatic pixel_t make_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                        logic [31:0] w);
    pixel_t px;
    px.red_sum    = r;
    px.green_sum  = g;
    px.blue_sum   = b;
    px.weight_sum = w;
    return px;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) expected_srgb.push_back(predict_srgb(pixel));
      if (!pixel_valid || pixel_ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pixel_valid <= 1'b1;
          pixel       <= pending_pixels.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    srgb_t want;
    if (rst) begin
      srgb_ready <= 1'b0;
    end else begin
      if (srgb_valid && srgb_ready) begin
        if (expected_srgb.size() == 0) begin
          $error("unexpected output item %h", srgb);
          mismatches++;
        end else begin
          want = expected_srgb.pop_front();
          if (srgb.red_srgb !== want.red_srgb) begin
            $error("red_srgb expected %h actual %h", want.red_srgb, srgb.red_srgb);
            mismatches++;
          end
          if (srgb.green_srgb !== want.green_srgb) begin
            $error("green_srgb expected %h actual %h", want.green_srgb, srgb.green_srgb);
            mismatches++;
          end
          if (srgb.blue_srgb !== want.blue_srgb) begin
            $error("blue_srgb expected %h actual %h", want.blue_srgb, srgb.blue_srgb);
            mismatches++;
          end
        end
      end
      srgb_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pixel_valid || expected_srgb.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero weight, extremes, linear threshold edge, huge quotients, negatives
    pending_pixels.push_back(make_pixel(32'h7fffffff, 32'h80000000, 32'h12345678, 32'h0));
    pending_pixels.push_back(make_pixel(32'h7fffffff, 32'h80000000, 32'h1, 32'h1));
    pending_pixels.push_back(make_pixel(32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff));
    pending_pixels.push_back(make_pixel(32'h80000000, 32'h7fffffff, 32'hffffffff,
                                        32'h80000000));
    pending_pixels.push_back(make_pixel(32'h7fffffff, 32'h0, 32'h80000000, 32'h7fffffff));
    pending_pixels.push_back(make_pixel(32'd52525, 32'd52526, 32'd52524, 32'h01000000));
    pending_pixels.push_back(make_pixel(-32'sd52525, 32'd52526, 32'd0, -32'sh01000000));
    pending_pixels.push_back(make_pixel(32'h01000000, 32'h00800000, 32'h02000000,
                                        32'h01000000));
    pending_pixels.push_back(make_pixel(32'h00010000, 32'h00000001, 32'h00ffffff,
                                        32'h00010000));
    pending_pixels.push_back(make_pixel(32'h0fff0000, 32'h7ff00000, 32'h00001000,
                                        32'h00010000));
    pending_pixels.push_back(make_pixel(-32'sh00010000, 32'h00008000, -32'sd1, 32'h00010000));
    pending_pixels.push_back(make_pixel(32'h00000001, 32'h00000002, 32'h00000003,
                                        32'h7fffffff));
    pending_pixels.push_back(make_pixel(32'h0000ffff, 32'h00010001, 32'h00080000,
                                        32'h00001000));
    for (int i = 0; i < 270; i++) pending_pixels.push_back(random_pixel());
    // hold off until the pipeline is empty
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct = 27;
    for (int i = 0; i < 290; i++) pending_pixels.push_back(random_pixel());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 290; i++) pending_pixels.push_back(random_pixel());
    wait_drained();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_srgb.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
